// ===== rtl/cfnp_pkg.sv =====
// Shared types, character codes and the digit decoder for the chunk file name parser.
package cfnp_pkg;

    // Position in the pattern c.<X>.<Z>.dat
    typedef enum logic [3:0] {
        PH_C,
        PH_DOT1,
        PH_X_START,
        PH_X_FIRST,
        PH_X_MORE,
        PH_Z_START,
        PH_Z_FIRST,
        PH_Z_MORE,
        PH_D,
        PH_A,
        PH_T,
        PH_DONE,
        PH_REJECT
    } t_phase;

    // Control part of the parse state, passed between the top level and the step logic
    typedef struct packed {
        t_phase phase;
        logic   x_neg;
        logic   z_neg;
    } t_flags;

    // Decoded base-36 digit
    typedef struct packed {
        logic       ok;
        logic [5:0] val;
    } t_digit;

    localparam int unsigned OUT_WIDTH = 32;
    localparam int unsigned EXT_WIDTH = 64;

    localparam logic [7:0] CH_C     = 8'h63;  // 'c'
    localparam logic [7:0] CH_DOT   = 8'h2E;  // '.'
    localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
    localparam logic [7:0] CH_D     = 8'h64;  // 'd'
    localparam logic [7:0] CH_A     = 8'h61;  // 'a'
    localparam logic [7:0] CH_T     = 8'h74;  // 't'
    localparam logic [7:0] CH_0     = 8'h30;  // '0'
    localparam logic [7:0] CH_9     = 8'h39;  // '9'
    localparam logic [7:0] CH_Z     = 8'h7A;  // 'z'
    localparam logic [5:0] ALPHA_OFFSET = 6'd10;

    // 0-9 give 0..9, a-z give 10..35, anything else is not a digit
    function automatic t_digit digit_of(input logic [7:0] ch);
        t_digit d;
        d.ok  = 1'b0;
        d.val = '0;
        if (ch >= CH_0 && ch <= CH_9) begin
            d.ok  = 1'b1;
            d.val = 6'(ch - CH_0);
        end else if (ch >= CH_A && ch <= CH_Z) begin
            d.ok  = 1'b1;
            d.val = 6'(ch - CH_A) + ALPHA_OFFSET;
        end
        return d;
    endfunction

endpackage

// ===== rtl/cfnp_step.sv =====
// Per-word update of the parse state and the result values of a finished name.
module cfnp_step #(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic [7:0]                       i_char_code,
    input  logic                             i_last,
    input  cfnp_pkg::t_flags                 i_flags,
    input  logic [VALUE_WIDTH-1:0]           i_x_acc,
    input  logic [VALUE_WIDTH-1:0]           i_z_acc,
    output cfnp_pkg::t_flags                 o_flags,
    output logic [VALUE_WIDTH-1:0]           o_x_acc,
    output logic [VALUE_WIDTH-1:0]           o_z_acc,
    output logic                             o_accepted,
    output logic signed [cfnp_pkg::OUT_WIDTH-1:0] o_chunk_x,
    output logic signed [cfnp_pkg::OUT_WIDTH-1:0] o_chunk_z
);

    cfnp_pkg::t_digit       digit;
    cfnp_pkg::t_phase       phase_nxt;
    logic                   x_neg_nxt;
    logic                   z_neg_nxt;
    logic [VALUE_WIDTH-1:0] x_acc_nxt;
    logic [VALUE_WIDTH-1:0] z_acc_nxt;
    logic [VALUE_WIDTH-1:0] x_push;
    logic [VALUE_WIDTH-1:0] z_push;
    logic [VALUE_WIDTH-1:0] x_signed;
    logic [VALUE_WIDTH-1:0] z_signed;
    logic signed [cfnp_pkg::EXT_WIDTH-1:0] x_ext;
    logic signed [cfnp_pkg::EXT_WIDTH-1:0] z_ext;

    assign digit = cfnp_pkg::digit_of(i_char_code);

    // acc * 36 + digit as two shifted adds, wrapping at VALUE_WIDTH
    assign x_push = (i_x_acc << 5) + (i_x_acc << 2) + VALUE_WIDTH'(digit.val);
    assign z_push = (i_z_acc << 5) + (i_z_acc << 2) + VALUE_WIDTH'(digit.val);

    // Next phase
    always_comb begin
        phase_nxt = cfnp_pkg::PH_REJECT;
        unique case (i_flags.phase)
            cfnp_pkg::PH_C: begin
                if (i_char_code == cfnp_pkg::CH_C) phase_nxt = cfnp_pkg::PH_DOT1;
            end
            cfnp_pkg::PH_DOT1: begin
                if (i_char_code == cfnp_pkg::CH_DOT) phase_nxt = cfnp_pkg::PH_X_START;
            end
            cfnp_pkg::PH_X_START, cfnp_pkg::PH_X_FIRST, cfnp_pkg::PH_X_MORE: begin
                priority if (i_flags.phase == cfnp_pkg::PH_X_START &&
                             i_char_code == cfnp_pkg::CH_MINUS) begin
                    phase_nxt = cfnp_pkg::PH_X_FIRST;
                end else if (i_flags.phase == cfnp_pkg::PH_X_MORE &&
                             i_char_code == cfnp_pkg::CH_DOT) begin
                    phase_nxt = cfnp_pkg::PH_Z_START;
                end else if (digit.ok) begin
                    phase_nxt = cfnp_pkg::PH_X_MORE;
                end else begin
                    phase_nxt = cfnp_pkg::PH_REJECT;
                end
            end
            cfnp_pkg::PH_Z_START, cfnp_pkg::PH_Z_FIRST, cfnp_pkg::PH_Z_MORE: begin
                priority if (i_flags.phase == cfnp_pkg::PH_Z_START &&
                             i_char_code == cfnp_pkg::CH_MINUS) begin
                    phase_nxt = cfnp_pkg::PH_Z_FIRST;
                end else if (i_flags.phase == cfnp_pkg::PH_Z_MORE &&
                             i_char_code == cfnp_pkg::CH_DOT) begin
                    phase_nxt = cfnp_pkg::PH_D;
                end else if (digit.ok) begin
                    phase_nxt = cfnp_pkg::PH_Z_MORE;
                end else begin
                    phase_nxt = cfnp_pkg::PH_REJECT;
                end
            end
            cfnp_pkg::PH_D: begin
                if (i_char_code == cfnp_pkg::CH_D) phase_nxt = cfnp_pkg::PH_A;
            end
            cfnp_pkg::PH_A: begin
                if (i_char_code == cfnp_pkg::CH_A) phase_nxt = cfnp_pkg::PH_T;
            end
            cfnp_pkg::PH_T: begin
                if (i_char_code == cfnp_pkg::CH_T) phase_nxt = cfnp_pkg::PH_DONE;
            end
            default: phase_nxt = cfnp_pkg::PH_REJECT;
        endcase
    end

    // Accumulators and sign flags follow the field that is being read
    always_comb begin
        x_acc_nxt = i_x_acc;
        z_acc_nxt = i_z_acc;
        x_neg_nxt = i_flags.x_neg;
        z_neg_nxt = i_flags.z_neg;
        if (phase_nxt == cfnp_pkg::PH_X_FIRST) x_neg_nxt = 1'b1;
        if (phase_nxt == cfnp_pkg::PH_X_MORE)  x_acc_nxt = x_push;
        if (phase_nxt == cfnp_pkg::PH_Z_FIRST) z_neg_nxt = 1'b1;
        if (phase_nxt == cfnp_pkg::PH_Z_MORE)  z_acc_nxt = z_push;
    end

    // Finished values: negate if signed, sign-extend, keep the low 32 bits
    assign x_signed = x_neg_nxt ? (VALUE_WIDTH'(0) - x_acc_nxt) : x_acc_nxt;
    assign z_signed = z_neg_nxt ? (VALUE_WIDTH'(0) - z_acc_nxt) : z_acc_nxt;
    assign x_ext    = cfnp_pkg::EXT_WIDTH'(signed'(x_signed));
    assign z_ext    = cfnp_pkg::EXT_WIDTH'(signed'(z_signed));

    assign o_accepted = (phase_nxt == cfnp_pkg::PH_DONE);
    assign o_chunk_x  = o_accepted ? x_ext[cfnp_pkg::OUT_WIDTH-1:0] : '0;
    assign o_chunk_z  = o_accepted ? z_ext[cfnp_pkg::OUT_WIDTH-1:0] : '0;

    // A finished name returns the parser to its reset state
    always_comb begin
        if (i_last) begin
            o_flags.phase = cfnp_pkg::PH_C;
            o_flags.x_neg = 1'b0;
            o_flags.z_neg = 1'b0;
            o_x_acc       = '0;
            o_z_acc       = '0;
        end else begin
            o_flags.phase = phase_nxt;
            o_flags.x_neg = x_neg_nxt;
            o_flags.z_neg = z_neg_nxt;
            o_x_acc       = x_acc_nxt;
            o_z_acc       = z_acc_nxt;
        end
    end

endmodule

// ===== rtl/chunk_file_name_parser.sv =====
// Top level of the chunk file name parser: input register, parse state and result register.
// Checks a file name, one byte per word, against c.<X>.<Z>.dat, where X and Z are an
// optional '-' and one or more base-36 digits (0-9, a-z) accumulated modulo 2^VALUE_WIDTH.
// Mark the final byte with i_last; that word yields one result word carrying o_accepted
// and the two signed values (zero when rejected), and other words yield none. A word is
// held in the input register, and the result word of a final byte is registered in the
// result register. A new word is accepted every cycle; the only stall is a final byte
// waiting behind a held result word while i_ready is low. After a final byte the parser
// is back at its reset state for the next name.
module chunk_file_name_parser #(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_char_code,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_accepted,
    output logic signed [31:0] o_chunk_x,
    output logic signed [31:0] o_chunk_z
);

    logic                   r_in_valid;
    logic [7:0]             r_in_char;
    logic                   r_in_last;
    cfnp_pkg::t_flags       r_flags;
    logic [VALUE_WIDTH-1:0] r_x_acc;
    logic [VALUE_WIDTH-1:0] r_z_acc;
    logic                   r_out_valid;
    logic                   r_out_accepted;
    logic signed [31:0]     r_out_x;
    logic signed [31:0]     r_out_z;

    cfnp_pkg::t_flags       n_flags;
    logic [VALUE_WIDTH-1:0] n_x_acc;
    logic [VALUE_WIDTH-1:0] n_z_acc;
    logic                   n_accepted;
    logic signed [31:0]     n_out_x;
    logic signed [31:0]     n_out_z;

    logic out_free;
    logic s2_fire;

    // The registered word moves on unless it is a final byte and the result slot is held
    assign out_free = !r_out_valid || i_ready;
    assign s2_fire  = r_in_valid && (!r_in_last || out_free);
    assign o_ready  = !r_in_valid || s2_fire;

    cfnp_step #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_step (
        .i_char_code (r_in_char),
        .i_last      (r_in_last),
        .i_flags     (r_flags),
        .i_x_acc     (r_x_acc),
        .i_z_acc     (r_z_acc),
        .o_flags     (n_flags),
        .o_x_acc     (n_x_acc),
        .o_z_acc     (n_z_acc),
        .o_accepted  (n_accepted),
        .o_chunk_x   (n_out_x),
        .o_chunk_z   (n_out_z)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_char <= i_char_code;
            r_in_last <= i_last;
        end
    end

    // Parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags.phase <= cfnp_pkg::PH_C;
            r_flags.x_neg <= 1'b0;
            r_flags.z_neg <= 1'b0;
            r_x_acc       <= '0;
            r_z_acc       <= '0;
        end else if (s2_fire) begin
            r_flags <= n_flags;
            r_x_acc <= n_x_acc;
            r_z_acc <= n_z_acc;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_fire && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_fire && r_in_last) begin
            r_out_accepted <= n_accepted;
            r_out_x        <= n_out_x;
            r_out_z        <= n_out_z;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_accepted = r_out_accepted;
    assign o_chunk_x  = r_out_x;
    assign o_chunk_z  = r_out_z;

`ifndef SYNTHESIS
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_accepted |-> o_chunk_x == 32'sd0 && o_chunk_z == 32'sd0)
        else $error("rejected name carries nonzero values");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_fire && r_in_last |=> r_flags.phase == cfnp_pkg::PH_C && r_x_acc == '0 &&
            r_z_acc == '0)
        else $error("parser not back at reset state after final byte");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_ready |-> !(s2_fire && r_in_last))
        else $error("held result word overwritten");
`endif

endmodule

// ===== tb/chunk_file_name_parser_tb.sv =====
// Self-checking testbench for the chunk file name parser: byte stream in, parse result out.
module chunk_file_name_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BYTE_TARGET = 1550;
    localparam int LONG_HOLD   = 500;

    typedef struct packed {
        logic        accepted;
        logic [31:0] x;
        logic [31:0] z;
    } t_result;

    // Tracks the parse of each name and holds the results still owed by the block
    class name_scoreboard;
        cfnp_pkg::t_phase phase;
        logic [31:0]      x_acc;
        logic [31:0]      z_acc;
        logic             x_neg;
        logic             z_neg;
        t_result          owed_q[$];
        int               errors;
        int               names_done;
        int               names_ok;

        function new();
            errors     = 0;
            names_done = 0;
            names_ok   = 0;
            restart();
        endfunction

        function void restart();
            phase = cfnp_pkg::PH_C;
            x_acc = '0;
            z_acc = '0;
            x_neg = 1'b0;
            z_neg = 1'b0;
        endfunction

        // Base-36 value of a byte, -1 when it is not a digit
        function int base36(logic [7:0] ch);
            if (ch >= cfnp_pkg::CH_0 && ch <= cfnp_pkg::CH_9) begin
                return int'(ch - cfnp_pkg::CH_0);
            end
            if (ch >= cfnp_pkg::CH_A && ch <= cfnp_pkg::CH_Z) begin
                return int'(ch - cfnp_pkg::CH_A) + 10;
            end
            return -1;
        endfunction

        // One coordinate: optional sign, at least one digit, closed by '.'
        function cfnp_pkg::t_phase field_next(cfnp_pkg::t_phase ph, cfnp_pkg::t_phase start,
                                              cfnp_pkg::t_phase after,
                                              logic [7:0] ch, inout logic [31:0] acc,
                                              inout logic neg);
            int d;
            d = base36(ch);
            if (ph == start && ch == cfnp_pkg::CH_MINUS) begin
                neg = 1'b1;
                return cfnp_pkg::t_phase'(start + 1);
            end
            if (ph == cfnp_pkg::t_phase'(start + 2) && ch == cfnp_pkg::CH_DOT) begin
                return after;
            end
            if (d >= 0) begin
                acc = acc * 32'd36 + 32'(d);
                return cfnp_pkg::t_phase'(start + 2);
            end
            return cfnp_pkg::PH_REJECT;
        endfunction

        // Accepted input word: advance the parse, owe a result on the final byte
        function void note_byte(logic [7:0] ch, logic last);
            t_result r;
            case (phase)
                cfnp_pkg::PH_C:
                    phase = (ch == cfnp_pkg::CH_C) ? cfnp_pkg::PH_DOT1 : cfnp_pkg::PH_REJECT;
                cfnp_pkg::PH_DOT1:
                    phase = (ch == cfnp_pkg::CH_DOT) ? cfnp_pkg::PH_X_START
                                                     : cfnp_pkg::PH_REJECT;
                cfnp_pkg::PH_X_START, cfnp_pkg::PH_X_FIRST, cfnp_pkg::PH_X_MORE:
                    phase = field_next(phase, cfnp_pkg::PH_X_START, cfnp_pkg::PH_Z_START,
                                       ch, x_acc, x_neg);
                cfnp_pkg::PH_Z_START, cfnp_pkg::PH_Z_FIRST, cfnp_pkg::PH_Z_MORE:
                    phase = field_next(phase, cfnp_pkg::PH_Z_START, cfnp_pkg::PH_D,
                                       ch, z_acc, z_neg);
                cfnp_pkg::PH_D:
                    phase = (ch == cfnp_pkg::CH_D) ? cfnp_pkg::PH_A : cfnp_pkg::PH_REJECT;
                cfnp_pkg::PH_A:
                    phase = (ch == cfnp_pkg::CH_A) ? cfnp_pkg::PH_T : cfnp_pkg::PH_REJECT;
                cfnp_pkg::PH_T:
                    phase = (ch == cfnp_pkg::CH_T) ? cfnp_pkg::PH_DONE : cfnp_pkg::PH_REJECT;
                default: phase = cfnp_pkg::PH_REJECT;
            endcase
            if (!last) begin
                return;
            end
            r = '0;
            if (phase == cfnp_pkg::PH_DONE) begin
                r.accepted = 1'b1;
                r.x        = x_neg ? (32'd0 - x_acc) : x_acc;
                r.z        = z_neg ? (32'd0 - z_acc) : z_acc;
                names_ok++;
            end
            owed_q.push_back(r);
            names_done++;
            restart();
        endfunction

        // Accepted result word against the oldest owed result
        function void check_result(logic accepted, logic [31:0] x, logic [31:0] z);
            t_result e;
            if (owed_q.size() == 0) begin
                $display("%0t: result word with none owed: accepted=%0b x=%0d z=%0d",
                         $time, accepted, $signed(x), $signed(z));
                errors++;
                return;
            end
            e = owed_q.pop_front();
            if (accepted !== e.accepted) begin
                $display("%0t: accepted mismatch: expected %0b, got %0b",
                         $time, e.accepted, accepted);
                errors++;
            end
            if (x !== e.x) begin
                $display("%0t: chunk_x mismatch: expected %0d, got %0d",
                         $time, $signed(e.x), $signed(x));
                errors++;
            end
            if (z !== e.z) begin
                $display("%0t: chunk_z mismatch: expected %0d, got %0d",
                         $time, $signed(e.z), $signed(z));
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [7:0]         i_char_code;
    logic               i_last;
    logic               o_valid;
    logic               i_ready;
    logic               o_accepted;
    logic signed [31:0] o_chunk_x;
    logic signed [31:0] o_chunk_z;

    name_scoreboard sb = new();
    logic [7:0]     name_buf[$];
    int             bytes_sent;
    int             bytes_accepted;
    bit             long_hold_done;

    chunk_file_name_parser u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_char_code (i_char_code),
        .i_last      (i_last),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_accepted  (o_accepted),
        .o_chunk_x   (o_chunk_x),
        .o_chunk_z   (o_chunk_z)
    );

    // 12 ns clock
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Handshake monitor: feeds the scoreboard on both channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                sb.note_byte(i_char_code, i_last);
                bytes_accepted++;
            end
            if (o_valid && i_ready) begin
                sb.check_result(o_accepted, o_chunk_x, o_chunk_z);
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off to back up the input
    initial begin
        int on_len;
        int off_len;
        i_ready        <= 1'b0;
        long_hold_done  = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (!long_hold_done && bytes_accepted >= 400) begin
                long_hold_done = 1'b1;
                i_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            on_len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                 : $urandom_range(1, 8);
            repeat (on_len) @(posedge i_clk);
            i_ready <= 1'b0;
            off_len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50)
                                                  : $urandom_range(1, 3);
            repeat (off_len) @(posedge i_clk);
        end
    end

    // Mostly back-to-back, sometimes a short gap, rarely a long pause
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Offer one word and hold it until it is taken
    task automatic send_byte(input logic [7:0] ch, input logic last);
        i_valid     <= 1'b1;
        i_char_code <= ch;
        i_last      <= last;
        do @(posedge i_clk); while (!o_ready);
        bytes_sent++;
    endtask

    task automatic send_name(input bit no_gaps);
        int gap;
        foreach (name_buf[i]) begin
            send_byte(name_buf[i], i == name_buf.size() - 1);
            gap = no_gaps ? 0 : pick_gap();
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            name_buf.push_back(s[i]);
        end
    endfunction

    // Optional sign and a run of base-36 digits, usually short
    function automatic void put_field();
        int n;
        int d;
        if ($urandom_range(0, 1)) begin
            name_buf.push_back(cfnp_pkg::CH_MINUS);
        end
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 13) : $urandom_range(1, 4);
        repeat (n) begin
            d = $urandom_range(0, 35);
            name_buf.push_back(d < 10 ? cfnp_pkg::CH_0 + 8'(d)
                                      : cfnp_pkg::CH_A + 8'(d - 10));
        end
    endfunction

    // Mostly well-formed names, the rest corrupted, cut short, extended or noise
    function automatic void build_random_name();
        logic [7:0] marks[5];
        int         kind;
        int         pos;
        marks = '{cfnp_pkg::CH_MINUS, cfnp_pkg::CH_DOT, cfnp_pkg::CH_C, cfnp_pkg::CH_D,
                  cfnp_pkg::CH_T};
        name_buf.delete();
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
            repeat ($urandom_range(1, 12)) name_buf.push_back(8'($urandom_range(0, 255)));
            return;
        end
        put_text("c.");
        put_field();
        name_buf.push_back(cfnp_pkg::CH_DOT);
        put_field();
        put_text(".dat");
        pos = $urandom_range(0, name_buf.size() - 1);
        if (kind < 75) begin
            return;
        end else if (kind < 83) begin
            name_buf[pos] = 8'($urandom_range(0, 255));
        end else if (kind < 89) begin
            repeat ($urandom_range(1, name_buf.size() - 1)) void'(name_buf.pop_back());
        end else if (kind < 95) begin
            repeat ($urandom_range(1, 3)) name_buf.push_back(8'($urandom_range(0, 255)));
        end else begin
            name_buf[pos] = marks[$urandom_range(0, 4)];
        end
    endfunction

    // Stimulus
    initial begin
        string dir_names[] = '{
            "c.0.0.dat", "c.zik0zj.-zik0zk.dat", "c.-1.-1.dat",
            "c.zzzzzzzzzzzzz.-zzzzzzzzzzzzz.dat", "c.-9az.z09.dat",
            "c.1.2.datc", "c.1.2.da", "c", "x", "C.1.2.dat", "c.-.1.dat",
            "c..1.dat", "c.1..dat", "c.1-.1.dat", "c.--1.2.dat", "c.1.2dat",
            "c.1.2..dat", "c.1.2.dax"
        };
        bytes_sent     = 0;
        bytes_accepted = 0;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_char_code <= '0;
        i_last      <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed names: value extremes, several ways to break the pattern
        foreach (dir_names[i]) begin
            name_buf.delete();
            put_text(dir_names[i]);
            send_name(i % 2 == 0);
        end
        // A zero byte inside a name, and a lone all-ones byte
        name_buf.delete();
        put_text("c.1");
        name_buf.push_back(8'h00);
        put_text(".2.dat");
        send_name(1'b0);
        name_buf.delete();
        name_buf.push_back(8'hFF);
        send_name(1'b0);

        // Random names, about one in eight sent without gaps
        while (bytes_sent < BYTE_TARGET) begin
            build_random_name();
            send_name($urandom_range(0, 7) == 0);
        end
        i_valid <= 1'b0;
        // Let the monitor record the last accepted word before draining
        @(posedge i_clk);

        while (sb.owed_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.owed_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, sb.owed_q.size());
            sb.errors++;
        end

        $display("Run covered %0d names (%0d matched, %0d rejected) in %0d words,",
                 sb.names_done, sb.names_ok, sb.names_done - sb.names_ok, bytes_accepted);
        $display("with random gaps on both sides and one %0d-cycle output hold-off.",
                 LONG_HOLD);
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("Timeout at %0t", $time);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
